FILE: design/cdq_pkg.sv
// cdq_pkg: shared types, constants and fp32 arithmetic functions
// for the codebook dequantizing dot product; no dependencies
package cdq_pkg;

   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
   localparam int unsigned NUM_REGS  = 4;
   localparam int unsigned ADDR_W    = 5;

   typedef struct packed {
      logic valid;
      logic odd;
      logic last;
   } cdq_item_type;

   // round sign * m * 2^e to fp32, round to nearest even, m nonzero
   function automatic logic [31:0] cdq_round(input logic s, input logic [35:0] m,
                                             input logic signed [11:0] e);
      logic [5:0]         lead;
      logic signed [11:0] sh_n;
      logic signed [11:0] sh_s;
      logic signed [11:0] sh;
      logic signed [11:0] exp_m1;
      logic [5:0]         nsh;
      logic [71:0]        wide;
      logic [24:0]        q;
      logic               g;
      logic               st;
      logic [35:0]        big;
      lead = '0;
      for (int i = 0; i < 36; i++) begin
         if (m[i]) lead = 6'(i);
      end
      sh_n = $signed({6'b0, lead}) - 12'sd23;
      sh_s = -12'sd149 - e;
      sh = (sh_s > sh_n) ? sh_s : sh_n;
      wide = '0;
      if (sh < 0) begin
         nsh = 6'(-sh);
         q = 25'(m << nsh);
         g = 1'b0;
         st = 1'b0;
      end else begin
         wide = {m, 36'b0} >> sh[5:0];
         q = wide[60:36];
         g = wide[35];
         st = |wide[34:0];
      end
      q = q + 25'(g & (st | q[0]));
      exp_m1 = $signed({6'b0, lead}) + e + 12'sd126;
      if (exp_m1 < 0) exp_m1 = '0;
      big = (36'(exp_m1[8:0]) << 23) + 36'(q);
      if (big >= 36'(INF_BITS)) begin
         return {s, INF_BITS[30:0]};
      end
      return {s, big[30:0]};
   endfunction

   // fp16 centroid times fp32 activation, rounded to fp32
   function automatic logic [31:0] cdq_mul(input logic [15:0] h, input logic [31:0] a);
      logic               w_zero;
      logic               w_inf;
      logic               w_nan;
      logic               a_zero;
      logic               a_inf;
      logic               a_nan;
      logic               s;
      logic [10:0]        sig_w;
      logic [23:0]        sig_a;
      logic signed [11:0] ew;
      logic signed [11:0] ea;
      w_zero = (h[14:10] == 5'd0) && (h[9:0] == 10'd0);
      w_inf  = (h[14:10] == 5'h1f) && (h[9:0] == 10'd0);
      w_nan  = (h[14:10] == 5'h1f) && (h[9:0] != 10'd0);
      a_zero = (a[30:23] == 8'd0) && (a[22:0] == 23'd0);
      a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
      a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      s = h[15] ^ a[31];
      sig_w = {h[14:10] != 5'd0, h[9:0]};
      sig_a = {a[30:23] != 8'd0, a[22:0]};
      ew = (h[14:10] == 5'd0) ? -12'sd24 : $signed({7'b0, h[14:10]}) - 12'sd25;
      ea = (a[30:23] == 8'd0) ? -12'sd149 : $signed({4'b0, a[30:23]}) - 12'sd150;
      if (w_nan || a_nan || (w_inf && a_zero) || (w_zero && a_inf)) return CANON_NAN;
      if (w_inf || a_inf) return {s, INF_BITS[30:0]};
      if (w_zero || a_zero) return {s, 31'b0};
      return cdq_round(s, 36'(sig_w * sig_a), ew + ea);
   endfunction

   // fp32 add, rounded to nearest even
   function automatic logic [31:0] cdq_add(input logic [31:0] x_in, input logic [31:0] y_in);
      logic [31:0]        x;
      logic [31:0]        y;
      logic               x_nan;
      logic               y_nan;
      logic               x_inf;
      logic               y_inf;
      logic [23:0]        sx;
      logic [23:0]        sy;
      logic signed [11:0] ex;
      logic signed [11:0] ey;
      logic [11:0]        d;
      logic [53:0]        ys;
      logic [26:0]        xv;
      logic [26:0]        yv;
      logic [27:0]        sum;
      logic               s;
      x_nan = (x_in[30:23] == 8'hff) && (x_in[22:0] != 23'd0);
      y_nan = (y_in[30:23] == 8'hff) && (y_in[22:0] != 23'd0);
      x_inf = (x_in[30:23] == 8'hff) && (x_in[22:0] == 23'd0);
      y_inf = (y_in[30:23] == 8'hff) && (y_in[22:0] == 23'd0);
      if (x_nan || y_nan || (x_inf && y_inf && (x_in[31] != y_in[31]))) return CANON_NAN;
      if (x_inf) return x_in;
      if (y_inf) return y_in;
      if (y_in[30:23] > x_in[30:23]) begin
         x = y_in;
         y = x_in;
      end else begin
         x = x_in;
         y = y_in;
      end
      sx = {x[30:23] != 8'd0, x[22:0]};
      sy = {y[30:23] != 8'd0, y[22:0]};
      ex = (x[30:23] == 8'd0) ? -12'sd149 : $signed({4'b0, x[30:23]}) - 12'sd150;
      ey = (y[30:23] == 8'd0) ? -12'sd149 : $signed({4'b0, y[30:23]}) - 12'sd150;
      d = 12'(ex - ey);
      if (d > 12'd27) d = 12'd27;
      ys = {sy, 3'b0, 27'b0} >> d[4:0];
      xv = {sx, 3'b0};
      yv = ys[53:27] | 27'(|ys[26:0]);
      if (x[31] == y[31]) begin
         sum = 28'(xv) + 28'(yv);
         s = x[31];
      end else if (xv >= yv) begin
         sum = 28'(xv - yv);
         s = x[31];
      end else begin
         sum = 28'(yv - xv);
         s = y[31];
      end
      if (sum == 28'd0) return {x[31] & y[31], 31'b0};
      return cdq_round(s, 36'(sum), ex - 12'sd3);
   endfunction

endpackage

FILE: design/cdq_lane.sv
// cdq_lane: one multiply lane, fp16 centroid times fp32 activation
// registered product; depends on cdq_pkg
module cdq_lane
   import cdq_pkg::*;
(
   input  logic        clock,
   input  logic        load,
   input  logic [15:0] centroid,
   input  logic [31:0] act,
   output logic [31:0] prod
);

   logic [31:0] prod_ff;
   logic [31:0] prod_in;

   assign prod_in = cdq_mul(centroid, act);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

FILE: design/cdq_accum.sv
// cdq_accum: merging stage, adds lane products in order into the running sum
// one fp32 add per cycle unless stalled by out_free; depends on cdq_pkg
module cdq_accum
   import cdq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cdq_item_type item,
   input  logic [31:0]  prod_even,
   input  logic [31:0]  prod_odd,
   input  logic         out_free,
   output logic         consume,
   output logic         emit,
   output logic [31:0]  result
);

   logic        phase_ff;
   logic        phase_in;
   logic [31:0] acc_ff;
   logic [31:0] acc_in;
   logic [31:0] sum;
   logic        final_step;
   logic        fire;

   assign sum        = cdq_add(acc_ff, phase_ff ? prod_odd : prod_even);
   assign final_step = phase_ff || !item.odd;
   assign fire       = item.valid && (!final_step || !item.last || out_free);
   assign consume    = fire && final_step;
   assign emit       = consume && item.last;
   assign result     = ((sum[30:23] == 8'hff) && (sum[22:0] != 23'd0)) ? CANON_NAN : sum;

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      if (fire) begin
         phase_in = !final_step;
         acc_in   = emit ? 32'd0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         acc_ff   <= 32'd0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

FILE: design/codebook_dequant_dot_product.sv
// codebook_dequant_dot_product: top level, csr centroids, two multiply lanes,
// accumulator and output register; depends on cdq_pkg, cdq_lane, cdq_accum
//
//   channel | ports                                   | handshake
//   request | req_weight_byte, req_act_*,             | req_valid / req_stall
//           | req_odd_valid, req_last                 |
//   result  | rsp_dot_sum                             | rsp_valid / rsp_stall
//   csr     | csr_p*, 64-bit registers at 8*i         | psel/penable, pready=1
//
// a request's products are registered in the multiply lanes, then the
// accumulator adds them in order, the even product and then the odd one only
// when odd_valid is high; the accumulator's single fp32 adder limits the rate
// reset is synchronous and clears the running sum and all valids
// a stalled result holds; the last request of a sum waits for a free output
module codebook_dequant_dot_product
   import cdq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_weight_byte,
   input  logic [31:0]         req_act_even,
   input  logic [31:0]         req_act_odd,
   input  logic                req_odd_valid,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_dot_sum,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [63:0]         csr_pwdata,
   output logic [63:0]         csr_prdata,
   output logic                csr_pready
);

   logic [63:0]  cent_ff [NUM_REGS];
   logic         p_valid_ff;
   logic         p_valid_in;
   logic         p_odd_ff;
   logic         p_last_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic [31:0]  rsp_data_ff;
   logic         load;
   logic         consume;
   logic         emit;
   logic         out_free;
   logic [31:0]  prod_even;
   logic [31:0]  prod_odd;
   logic [31:0]  result;
   logic [15:0]  cent_even;
   logic [15:0]  cent_odd;
   cdq_item_type item;

   assign csr_pready = 1'b1;
   assign csr_prdata = cent_ff[csr_paddr[4:3]];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) cent_ff[i] <= 64'd0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         cent_ff[csr_paddr[4:3]] <= csr_pwdata;
      end
   end

   assign cent_even = cent_ff[req_weight_byte[3:2]][{req_weight_byte[1:0], 4'b0} +: 16];
   assign cent_odd  = cent_ff[req_weight_byte[7:6]][{req_weight_byte[5:4], 4'b0} +: 16];

   assign req_stall = p_valid_ff && !consume;
   assign load      = req_valid && !req_stall;

   cdq_lane u_lane_even (
      .clock    (clock),
      .load     (load),
      .centroid (cent_even),
      .act      (req_act_even),
      .prod     (prod_even)
   );

   cdq_lane u_lane_odd (
      .clock    (clock),
      .load     (load),
      .centroid (cent_odd),
      .act      (req_act_odd),
      .prod     (prod_odd)
   );

   assign p_valid_in = load || (p_valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         p_odd_ff  <= req_odd_valid;
         p_last_ff <= req_last;
      end
   end

   assign item.valid = p_valid_ff;
   assign item.odd   = p_odd_ff;
   assign item.last  = p_last_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   cdq_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .prod_even (prod_even),
      .prod_odd  (prod_odd),
      .out_free  (out_free),
      .consume   (consume),
      .emit      (emit),
      .result    (result)
   );

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_dot_sum = rsp_data_ff;

endmodule

FILE: design/cdq_checker.sv
// cdq_checker: port-level checks on the top level, bound to it below
// depends on codebook_dequant_dot_product ports only
module cdq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_odd_valid,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_dot_sum
);

   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   rsp_stable_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_dot_sum))
      else $error("stalled result changed");

   reset_idle_a: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   nan_canon_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_dot_sum[30:23] == 8'hff) && (rsp_dot_sum[22:0] != 23'd0)
      |-> rsp_dot_sum == 32'h7FC0_0000)
      else $error("non-canonical nan result");

   two_step_a: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_odd_valid |=> req_stall)
      else $error("request with two elements not given two adder cycles");

endmodule

bind codebook_dequant_dot_product cdq_checker u_cdq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_odd_valid (req_odd_valid),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_dot_sum   (rsp_dot_sum)
);
